@@ rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared codes and field widths of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	// Field widths fixed by the transaction format.
	localparam int IN_W   = 32;
	localparam int IDX_W  = 5;
	localparam int FRAG_W = 32;
	localparam int CNT_W  = 6;
	localparam int SUM_W  = 37;

	// Operation codes carried on func.
	localparam logic [1:0] FN_LOAD  = 2'd0;
	localparam logic [1:0] FN_ALLOC = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NOFIT = 2'd2
	} status_t;

endpackage

@@ rtl/ffba_ram.sv @@
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read on the same clock.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ffba_cmp.sv @@
// ----------------------------------------------------------------------------
// ffba_cmp
// Shared fit unit: one subtractor that both tests a table entry against the
// request and yields the leftover fragment.
// ----------------------------------------------------------------------------
module ffba_cmp #(
	parameter int SIZE_WIDTH = 32
) (
	input  logic [SIZE_WIDTH:0]   entry,
	input  logic [SIZE_WIDTH-1:0] req,
	output logic                  hit,
	output logic [SIZE_WIDTH-1:0] frag
);

	logic [SIZE_WIDTH:0] diff;

	// The top bit of the entry is the used mark; the borrow says the block is too small.
	always_comb begin
		diff = {1'b0, entry[SIZE_WIDTH-1:0]} - {1'b0, req};
		hit  = !entry[SIZE_WIDTH] && !diff[SIZE_WIDTH];
		frag = diff[SIZE_WIDTH-1:0];
	end

endmodule

@@ rtl/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a table of fixed-size blocks held in a RAM.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and its single
// result appears on the result ports for one cycle with done high; the
// receiver cannot hold it off. Load, clear and the unused code complete
// without a scan, with done in the following cycle, and busy stays low so
// that a new transaction may be offered straight away; so does an allocate
// against an empty table, which returns no fit. Any other allocate scans the
// size table one entry per cycle through the RAM read port and a single
// subtract and compare unit: a block found is marked used in the commit
// state, which raises done, and a search that fails raises done once the
// last loaded entry has been checked. Busy is high for the whole of the scan.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = 32,
	parameter int SIZE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [ffba_pkg::IN_W-1:0]   block_size,
	input  logic [ffba_pkg::IN_W-1:0]   request_size,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [ffba_pkg::IDX_W-1:0]  block_index,
	output logic [ffba_pkg::FRAG_W-1:0] fragment,
	output logic [ffba_pkg::CNT_W-1:0]  allocated_count,
	output logic [ffba_pkg::SUM_W-1:0]  fragment_sum
);

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic [ffba_pkg::CNT_W-1:0] files_q;
	logic [ffba_pkg::SUM_W-1:0] waste_q;
	logic [SIZE_WIDTH-1:0]     req_q;
	logic [CW-1:0]             rd_addr_q;
	logic                      chk_vld_q;
	logic [AW-1:0]             chk_idx_q;
	logic [AW-1:0]             cand_idx_q;
	logic [SIZE_WIDTH-1:0]     cand_size_q;
	logic [SIZE_WIDTH-1:0]     cand_frag_q;
	logic                      done_q;
	ffba_pkg::status_t         status_q;
	logic [ffba_pkg::IDX_W-1:0] index_q;
	logic [ffba_pkg::FRAG_W-1:0] frag_q;

	logic                      accept;
	logic                      issuing;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [SIZE_WIDTH:0]       ram_wdata;
	logic [SIZE_WIDTH:0]       ram_rdata;
	logic                      cmp_hit;
	logic [SIZE_WIDTH-1:0]     cmp_frag;
	logic [SIZE_WIDTH-1:0]     bsz;
	logic [SIZE_WIDTH-1:0]     req;
	logic [SIZE_WIDTH+ffba_pkg::IN_W-1:0]   bsz_ext;
	logic [SIZE_WIDTH+ffba_pkg::IN_W-1:0]   req_ext;
	logic [CW+ffba_pkg::IDX_W-1:0]          load_idx_ext;
	logic [AW+ffba_pkg::IDX_W-1:0]          cand_idx_ext;
	logic [SIZE_WIDTH+ffba_pkg::FRAG_W-1:0] cand_frag_ext;
	logic [SIZE_WIDTH+ffba_pkg::SUM_W-1:0]  cand_waste_ext;

	// Sizes are held at SIZE_WIDTH bits, results at the port widths: widen with zeros, then keep the low part.
	always_comb begin
		bsz_ext        = {{SIZE_WIDTH{1'b0}}, block_size};
		req_ext        = {{SIZE_WIDTH{1'b0}}, request_size};
		bsz            = bsz_ext[SIZE_WIDTH-1:0];
		req            = req_ext[SIZE_WIDTH-1:0];
		load_idx_ext   = {{ffba_pkg::IDX_W{1'b0}}, count_q};
		cand_idx_ext   = {{ffba_pkg::IDX_W{1'b0}}, cand_idx_q};
		cand_frag_ext  = {{ffba_pkg::FRAG_W{1'b0}}, cand_frag_q};
		cand_waste_ext = {{ffba_pkg::SUM_W{1'b0}}, cand_frag_q};
	end

	assign accept  = start && (state_q == S_IDLE);
	assign issuing = (rd_addr_q < count_q);

	// Table writes: a new block on load, or the used mark set on commit.
	always_comb begin
		if (state_q == S_COMMIT) begin
			ram_we    = 1'b1;
			ram_waddr = cand_idx_q;
			ram_wdata = {1'b1, cand_size_q};
		end else begin
			ram_we    = accept && (func == ffba_pkg::FN_LOAD) && (count_q < MAX_CNT);
			ram_waddr = count_q[AW-1:0];
			ram_wdata = {1'b0, bsz};
		end
	end

	ffba_ram #(
		.WIDTH (SIZE_WIDTH + 1),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	ffba_cmp #(
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_cmp (
		.entry (ram_rdata),
		.req   (req_q),
		.hit   (cmp_hit),
		.frag  (cmp_frag)
	);

	// Sequencer, counters and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			files_q     <= '0;
			waste_q     <= '0;
			req_q       <= '0;
			rd_addr_q   <= '0;
			chk_vld_q   <= 1'b0;
			chk_idx_q   <= '0;
			cand_idx_q  <= '0;
			cand_size_q <= '0;
			cand_frag_q <= '0;
			done_q      <= 1'b0;
			status_q    <= ffba_pkg::ST_OK;
			index_q     <= '0;
			frag_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (func)
							ffba_pkg::FN_LOAD: begin
								done_q <= 1'b1;
								frag_q <= '0;
								if (count_q >= MAX_CNT) begin
									status_q <= ffba_pkg::ST_FULL;
									index_q  <= '0;
								end else begin
									status_q <= ffba_pkg::ST_OK;
									index_q  <= load_idx_ext[ffba_pkg::IDX_W-1:0];
									count_q  <= count_q + CW'(1);
								end
							end
							ffba_pkg::FN_ALLOC: begin
								if (count_q == '0) begin
									done_q   <= 1'b1;
									status_q <= ffba_pkg::ST_NOFIT;
									index_q  <= '0;
									frag_q   <= '0;
								end else begin
									req_q     <= req;
									rd_addr_q <= '0;
									chk_vld_q <= 1'b0;
									state_q   <= S_SCAN;
								end
							end
							ffba_pkg::FN_CLEAR: begin
								done_q   <= 1'b1;
								status_q <= ffba_pkg::ST_OK;
								index_q  <= '0;
								frag_q   <= '0;
								count_q  <= '0;
								files_q  <= '0;
								waste_q  <= '0;
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= ffba_pkg::ST_OK;
								index_q  <= '0;
								frag_q   <= '0;
							end
						endcase
					end
				end
				S_SCAN: begin
					// One read issued and one entry checked per cycle.
					if (issuing) begin
						rd_addr_q <= rd_addr_q + CW'(1);
					end
					chk_vld_q <= issuing;
					chk_idx_q <= rd_addr_q[AW-1:0];
					if (chk_vld_q && cmp_hit) begin
						cand_idx_q  <= chk_idx_q;
						cand_size_q <= ram_rdata[SIZE_WIDTH-1:0];
						cand_frag_q <= cmp_frag;
						state_q     <= S_COMMIT;
					end else if (!issuing) begin
						done_q   <= 1'b1;
						status_q <= ffba_pkg::ST_NOFIT;
						index_q  <= '0;
						frag_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_COMMIT: begin
					// The used mark is written back while the counters advance.
					done_q   <= 1'b1;
					status_q <= ffba_pkg::ST_OK;
					index_q  <= cand_idx_ext[ffba_pkg::IDX_W-1:0];
					frag_q   <= cand_frag_ext[ffba_pkg::FRAG_W-1:0];
					files_q  <= files_q + ffba_pkg::CNT_W'(1);
					waste_q  <= waste_q + cand_waste_ext[ffba_pkg::SUM_W-1:0];
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign block_index     = index_q;
	assign fragment        = frag_q;
	assign allocated_count = files_q;
	assign fragment_sum    = waste_q;

`ifndef ASSERT_OFF
	// A result is only ever presented once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe raised outside the idle state");

	// The scan read pointer never runs past the loaded blocks.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rd_addr_q <= count_q))
		else $error("scan pointer beyond the loaded blocks");

	// An allocate against a non-empty table starts a scan.
	a_alloc_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == ffba_pkg::FN_ALLOC) && (count_q != '0)) |=> (state_q == S_SCAN))
		else $error("allocate did not start a scan");

	// A commit always follows a hit and is followed by a result strobe.
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |=> (done_q && (status_q == ffba_pkg::ST_OK)))
		else $error("commit without an ok result");

	// The table never holds more blocks than it has room for.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("block count beyond table size");
`endif

endmodule

@@ dv/first_fit_block_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Self-checking bench for the first-fit block allocator.
// ----------------------------------------------------------------------------
// A queue of commands is filled at time zero. It opens with a short directed
// list, followed by random sessions: mostly a clear, a run of loads and
// allocates shaped around the loaded sizes, and a little noise. A clocked
// driver offers the commands with random gaps. Each accepted transaction is
// run through a local model of the block table, and the outcome is queued.
// A clocked monitor compares every strobed result with the oldest outcome.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;

	localparam int          MAX_BLOCKS  = 32;
	localparam int          RAND_ITEMS  = 1450;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          TAIL_CYCLES = 40;
	localparam logic [1:0]  FN_SPARE    = 2'd3;

	typedef struct {
		logic [1:0]  fn;
		logic [31:0] bsz;
		logic [31:0] req;
		int          gap;
		bit          drain;
	} alloc_cmd_t;

	typedef struct {
		ffba_pkg::status_t           status_v;
		logic [ffba_pkg::IDX_W-1:0]  index_v;
		logic [ffba_pkg::FRAG_W-1:0] frag_v;
		logic [ffba_pkg::CNT_W-1:0]  count_v;
		logic [ffba_pkg::SUM_W-1:0]  sum_v;
	} alloc_result_t;

	// Ports of the block; every input starts at a known value.
	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [1:0]                  func = ffba_pkg::FN_LOAD;
	logic [ffba_pkg::IN_W-1:0]   block_size = '0;
	logic [ffba_pkg::IN_W-1:0]   request_size = '0;
	logic                        done;
	logic [1:0]                  status;
	logic [ffba_pkg::IDX_W-1:0]  block_index;
	logic [ffba_pkg::FRAG_W-1:0] fragment;
	logic [ffba_pkg::CNT_W-1:0]  allocated_count;
	logic [ffba_pkg::SUM_W-1:0]  fragment_sum;

	// Stimulus and expectation stores.
	alloc_cmd_t    cmd_queue [$];
	alloc_result_t awaited_results [$];
	int            idle_left = 0;
	int            mismatches = 0;
	int            cycle_count = 0;
	int            counted_cmds = 0;
	bit            quiet_stretch = 0;
	bit            drain_next = 0;

	// Local copy of the block table.
	logic [31:0]                tbl_size [MAX_BLOCKS];
	bit                         tbl_taken [MAX_BLOCKS];
	int                         tbl_loaded = 0;
	logic [ffba_pkg::CNT_W-1:0] files_done = '0;
	logic [ffba_pkg::SUM_W-1:0] waste_acc = '0;

	first_fit_block_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.block_size      (block_size),
		.request_size    (request_size),
		.done            (done),
		.status          (status),
		.block_index     (block_index),
		.fragment        (fragment),
		.allocated_count (allocated_count),
		.fragment_sum    (fragment_sum)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Work out the result of one accepted transaction and queue it.
	task automatic predict_allocation(input logic [1:0] fn, input logic [31:0] bsz,
			input logic [31:0] req);
		alloc_result_t o;
		bit            found;
		int            k;
		o.status_v = ffba_pkg::ST_OK;
		o.index_v  = '0;
		o.frag_v   = '0;
		found      = 0;
		case (fn)
			ffba_pkg::FN_LOAD: begin
				if (tbl_loaded >= MAX_BLOCKS) begin
					o.status_v = ffba_pkg::ST_FULL;
				end else begin
					tbl_size[tbl_loaded]  = bsz;
					tbl_taken[tbl_loaded] = 0;
					o.index_v = tbl_loaded[ffba_pkg::IDX_W-1:0];
					tbl_loaded++;
				end
			end
			ffba_pkg::FN_ALLOC: begin
				o.status_v = ffba_pkg::ST_NOFIT;
				for (k = 0; k < tbl_loaded && !found; k++) begin
					if (!tbl_taken[k] && tbl_size[k] >= req) begin
						found        = 1;
						tbl_taken[k] = 1;
						o.status_v   = ffba_pkg::ST_OK;
						o.index_v    = k[ffba_pkg::IDX_W-1:0];
						o.frag_v     = tbl_size[k] - req;
						files_done   = files_done + 1'b1;
						waste_acc    = waste_acc +
							{{(ffba_pkg::SUM_W-ffba_pkg::FRAG_W){1'b0}}, o.frag_v};
					end
				end
			end
			ffba_pkg::FN_CLEAR: begin
				for (k = 0; k < MAX_BLOCKS; k++)
					tbl_taken[k] = 0;
				tbl_loaded = 0;
				files_done = '0;
				waste_acc  = '0;
			end
			default: begin
				// The spare code leaves everything as it stands.
			end
		endcase
		o.count_v = files_done;
		o.sum_v   = waste_acc;
		awaited_results.push_back(o);
	endtask

	task automatic compare_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Queue one command with the gap that precedes it.
	task automatic push_cmd(input logic [1:0] fn, input logic [31:0] bsz,
			input logic [31:0] req);
		alloc_cmd_t c;
		c.fn    = fn;
		c.bsz   = bsz;
		c.req   = req;
		c.gap   = quiet_stretch ? 0 : $urandom_range(0, 7);
		c.drain = drain_next;
		drain_next = 0;
		counted_cmds++;
		cmd_queue.push_back(c);
	endtask

	function automatic logic [31:0] draw_size(input int style);
		logic [31:0] v;
		case (style)
			0: v = $urandom_range(0, 63);
			1: v = $urandom_range(0, 4095);
			2: begin
				case ($urandom_range(0, 5))
					0: v = 32'h0000_0000;
					1: v = 32'h0000_0001;
					2: v = 32'h7FFF_FFFF;
					3: v = 32'h8000_0000;
					4: v = 32'hFFFF_FFFE;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// A session of loads and allocations; the heavy one fills the table with
	// the largest blocks and drains it with zero-size requests.
	task automatic build_session(input bit heavy);
		logic [31:0] shadow [$];
		logic [31:0] s;
		logic [31:0] req;
		int          n_load;
		int          n_alloc;
		int          style;
		int          i;
		quiet_stretch = ($urandom_range(0, 3) == 0);
		if (heavy) begin
			push_cmd(ffba_pkg::FN_CLEAR, $urandom, $urandom);
			for (i = 0; i <= MAX_BLOCKS; i++)
				push_cmd(ffba_pkg::FN_LOAD, 32'hFFFF_FFFF, $urandom);
			for (i = 0; i <= MAX_BLOCKS; i++)
				push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'h0000_0000);
			push_cmd(FN_SPARE, $urandom, $urandom);
		end else begin
			if ($urandom_range(0, 9) != 0)
				push_cmd(ffba_pkg::FN_CLEAR, $urandom, $urandom);
			style   = $urandom_range(0, 3);
			n_load  = ($urandom_range(0, 5) == 0) ? $urandom_range(24, 36)
				: $urandom_range(1, 12);
			n_alloc = $urandom_range(1, n_load + 4);
			while (n_load > 0 || n_alloc > 0) begin
				if ($urandom_range(0, 15) == 0) begin
					// Noise: any code with arbitrary sizes.
					push_cmd(2'($urandom_range(0, 3)), $urandom, $urandom);
				end else if (n_load > 0 && (n_alloc == 0 || $urandom_range(0, 2) != 0)) begin
					s = draw_size(style);
					shadow.push_back(s);
					push_cmd(ffba_pkg::FN_LOAD, s, $urandom);
					n_load--;
				end else begin
					if (shadow.size() != 0 && $urandom_range(0, 3) != 0) begin
						s = shadow[$urandom_range(0, shadow.size() - 1)];
						case ($urandom_range(0, 3))
							0: req = s;
							1: req = s - $urandom_range(0, (s < 64) ? s : 63);
							2: req = s + 1;
							default: req = draw_size(style);
						endcase
					end else begin
						req = draw_size(style);
					end
					push_cmd(ffba_pkg::FN_ALLOC, $urandom, req);
					n_alloc--;
				end
			end
		end
	endtask

	// Stimulus, reset and the end of the run.
	initial begin
		int sessions;
		// Directed part: empty table, extremes, exhaustion and clear.
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'h0000_0000);
		push_cmd(FN_SPARE, $urandom, $urandom);
		push_cmd(ffba_pkg::FN_LOAD, 32'h0000_0000, $urandom);
		push_cmd(ffba_pkg::FN_LOAD, 32'hFFFF_FFFF, $urandom);
		push_cmd(ffba_pkg::FN_LOAD, 32'd100, $urandom);
		push_cmd(ffba_pkg::FN_LOAD, 32'hFFFF_FFFF, $urandom);
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'hFFFF_FFFF);
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'h0000_0000);
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'd50);
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'h0000_0000);
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'd1);
		push_cmd(FN_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(ffba_pkg::FN_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'h0000_0000);
		push_cmd(ffba_pkg::FN_LOAD, 32'd7, $urandom);
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'd8);
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'd7);
		push_cmd(ffba_pkg::FN_LOAD, 32'd9, $urandom);
		push_cmd(ffba_pkg::FN_ALLOC, $urandom, 32'd3);
		push_cmd(ffba_pkg::FN_CLEAR, $urandom, $urandom);

		// Random part; the first session is the heavy one and starts after
		// the directed results have all come back.
		drain_next = 1;
		build_session(1);
		sessions = 0;
		while (counted_cmds < RAND_ITEMS) begin
			sessions++;
			if (sessions % 8 == 0)
				drain_next = 1;
			build_session(sessions % 25 == 0);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || start)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Driver: offers queued commands and predicts each accepted transaction.
	always @(posedge clk) begin
		alloc_cmd_t nxt;
		bit         offering;
		if (arst_n) begin
			offering = start;
			if (start && !busy) begin
				predict_allocation(func, block_size, request_size);
				offering  = 0;
				idle_left = (cmd_queue.size() != 0) ? cmd_queue[0].gap : 0;
			end
			if (!offering) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (cmd_queue.size() != 0 &&
						!(cmd_queue[0].drain && awaited_results.size() != 0)) begin
					nxt          = cmd_queue.pop_front();
					func         <= nxt.fn;
					block_size   <= nxt.bsz;
					request_size <= nxt.req;
					start        <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result is checked against the oldest outcome.
	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0h index %0h",
					$time, status, block_index);
				mismatches++;
			end else begin
				e = awaited_results.pop_front();
				compare_field("status", e.status_v, status);
				compare_field("block_index", e.index_v, block_index);
				compare_field("fragment", e.frag_v, fragment);
				compare_field("allocated_count", e.count_v, allocated_count);
				compare_field("fragment_sum", e.sum_v, fragment_sum);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule
